// ===== design/pnr_pkg.sv =====
package pnr_pkg;
  localparam int unsigned DefMaxDegree = 5;
  localparam int unsigned DataW        = 32;
  localparam int unsigned DegW         = 3;
  localparam int unsigned IterW        = 8;
  localparam int unsigned StatW        = 2;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [StatW-1:0] StConverged = 2'd0;
  localparam logic [StatW-1:0] StZeroDeriv = 2'd1;
  localparam logic [StatW-1:0] StIterLimit = 2'd2;
  localparam logic [StatW-1:0] StDuplicate = 2'd3;

  localparam logic [CfgIdxW-1:0] RegDegree = 3'd6;
  localparam logic [CfgIdxW-1:0] RegIterLimit = 3'd7;

  localparam logic signed [DataW-1:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

  function automatic logic signed [DataW-1:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'(SatMax);
    lo = 64'(SatMin);
    if (v > hi) return SatMax;
    if (v < lo) return SatMin;
    return v[DataW-1:0];
  endfunction
endpackage

// ===== design/pnr_if.sv =====
interface pnr_in_if;
  import pnr_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] start_guess;
  modport source (output valid, output start_guess, input ready);
  modport sink   (input valid, input start_guess, output ready);
endinterface

interface pnr_out_if;
  import pnr_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] root_value;
  logic [StatW-1:0] result_status;
  logic [IterW-1:0] iterations_used;
  modport source (output valid, output root_value, output result_status,
                  output iterations_used, input ready);
  modport sink   (input valid, input root_value, input result_status,
                  input iterations_used, output ready);
endinterface

interface pnr_cfg_if;
  import pnr_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/polynomial_newton_root_top.sv =====
// Newton-Raphson root finder for a polynomial of degree 0..5 in signed Q16.16.
// Write coefficients (index 0..5), degree (6) and iteration limit (7) while idle.
// Each start guess yields one word: root, status (0 converged, 1 zero
// derivative, 2 iteration limit, 3 repeat of the previous root) and step count.
// One multiplier evaluates f and f' by Horner's rule (a multiply step and an
// add step per coefficient) and a restoring divider forms f/f' one quotient
// bit a cycle (49 bits). The block takes no guess while one is at work or
// while its result waits at the output.
module polynomial_newton_root_top
  import pnr_pkg::*;
#(
  parameter int unsigned MaxDegree = DefMaxDegree
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pnr_in_if.sink    in_if,
  pnr_out_if.source out_if,
  pnr_cfg_if.sink   cfg_if
);
  typedef enum logic [3:0] {
    S_IDLE, S_DCOEF, S_FSTART, S_FMUL, S_FADD, S_DSTART, S_DMUL, S_DADD,
    S_DIVSET, S_DIV, S_UPDATE, S_FINISH, S_OUT
  } state_e;

  localparam int unsigned NCoef = MaxDegree + 1;
  localparam int unsigned KW    = $clog2(NCoef + 1);
  localparam int unsigned DivW  = 49;  // |f|*65536 fits in 48 bits

  state_e state_q;
  logic signed [DataW-1:0] coef_q  [NCoef];
  logic signed [DataW-1:0] dcoef_q [NCoef];
  logic [DegW-1:0]  deg_q, deg_eff;
  logic [IterW-1:0] limit_q, n_q;
  logic signed [DataW-1:0] x_q, acc_q, f_q, prev_q;
  logic prev_valid_q;
  logic [KW-1:0] k_q;
  logic signed [63:0] prod_q;
  logic [DivW-1:0] num_q, quo_q;
  logic [DataW:0]  den_q;
  logic [DivW:0]   rem_q;
  logic [5:0]      dcnt_q;
  logic            qneg_q;
  logic [StatW-1:0] status_q;

  logic signed [63:0] mul_res;
  logic signed [DataW-1:0] mul_a;
  logic [DivW:0] rem_sh;
  logic signed [63:0] qs;
  logic signed [DataW-1:0] q32, xn;

  assign deg_eff = (deg_q > DegW'(MaxDegree)) ? DegW'(MaxDegree) : deg_q;
  assign mul_a   = (state_q == S_DCOEF) ? DataW'(k_q) : acc_q;
  assign mul_res = 64'(mul_a) * 64'(state_q == S_DCOEF ? coef_q[k_q] : x_q);
  assign rem_sh  = {rem_q[DivW-1:0], num_q[DivW-1]};
  assign qs      = qneg_q ? -$signed(64'(quo_q)) : $signed(64'(quo_q));
  assign q32     = sat64(qs);
  assign xn      = sat64(64'(x_q) - 64'(q32));

  assign in_if.ready         = (state_q == S_IDLE);
  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = (state_q == S_OUT);
  assign out_if.root_value   = x_q;
  assign out_if.result_status = status_q;
  assign out_if.iterations_used = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < NCoef; i++) coef_q[i] <= '0;
      deg_q <= DegW'(1);
      limit_q <= IterW'(32);
      prev_q <= '0;
      prev_valid_q <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        if (cfg_if.index == RegDegree) deg_q <= cfg_if.data[DegW-1:0];
        else if (cfg_if.index == RegIterLimit) limit_q <= cfg_if.data[IterW-1:0];
        else if (32'(cfg_if.index) < NCoef) coef_q[cfg_if.index] <= cfg_if.data;
      end
      unique case (state_q)
        S_IDLE: if (in_if.valid) begin
          x_q <= in_if.start_guess;
          n_q <= '0;
          k_q <= KW'(1);
          for (int i = 0; i < NCoef; i++) dcoef_q[i] <= '0;
          state_q <= S_DCOEF;
        end
        S_DCOEF: begin
          if (32'(k_q) <= 32'(deg_eff) && 32'(k_q) < NCoef) begin
            dcoef_q[k_q-1'b1] <= sat64(mul_res);
            k_q <= k_q + 1'b1;
          end else state_q <= S_FSTART;
        end
        S_FSTART: begin
          if (n_q >= limit_q) begin
            status_q <= StIterLimit;
            state_q <= S_FINISH;
          end else begin
            acc_q <= coef_q[deg_eff];
            k_q <= KW'(deg_eff);
            state_q <= (deg_eff == '0) ? S_DSTART : S_FMUL;
          end
        end
        S_FMUL: begin
          if (k_q == '0) begin
            f_q <= acc_q;
            state_q <= S_DSTART;
          end else begin
            prod_q <= mul_res;
            k_q <= k_q - 1'b1;
            state_q <= S_FADD;
          end
        end
        S_FADD: begin
          acc_q <= sat64(64'(sat64(prod_q >>> 16)) + 64'(coef_q[k_q]));
          state_q <= S_FMUL;
        end
        S_DSTART: begin
          if (deg_eff == '0) begin
            status_q <= StZeroDeriv;
            state_q <= S_OUT;
          end else begin
            acc_q <= dcoef_q[deg_eff-1'b1];
            k_q <= KW'(deg_eff - 1'b1);
            state_q <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (k_q == '0) state_q <= S_DIVSET;
          else begin
            prod_q <= mul_res;
            k_q <= k_q - 1'b1;
            state_q <= S_DADD;
          end
        end
        S_DADD: begin
          acc_q <= sat64(64'(sat64(prod_q >>> 16)) + 64'(dcoef_q[k_q]));
          state_q <= S_DMUL;
        end
        S_DIVSET: begin
          if (acc_q == '0) begin
            status_q <= StZeroDeriv;
            state_q <= S_OUT;
          end else begin
            num_q <= {1'b0, (f_q[DataW-1] ? 32'(-33'(f_q)) : f_q), 16'd0};
            den_q <= acc_q[DataW-1] ? (-(33'(acc_q))) : 33'(acc_q);
            qneg_q <= f_q[DataW-1] ^ acc_q[DataW-1];
            rem_q <= '0;
            quo_q <= '0;
            dcnt_q <= 6'(DivW);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // one restoring step a cycle, MSB first
          if (dcnt_q == '0) state_q <= S_UPDATE;
          else begin
            num_q <= {num_q[DivW-2:0], 1'b0};
            if (rem_sh >= (DivW+1)'(den_q)) begin
              rem_q <= rem_sh - (DivW+1)'(den_q);
              quo_q <= {quo_q[DivW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[DivW-2:0], 1'b0};
            end
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        S_UPDATE: begin
          n_q <= n_q + 1'b1;
          if (xn == x_q) begin
            status_q <= StConverged;
            state_q <= S_FINISH;
          end else begin
            x_q <= xn;
            state_q <= S_FSTART;
          end
        end
        S_FINISH: begin
          if (prev_valid_q && prev_q == x_q) status_q <= StDuplicate;
          else begin
            prev_q <= x_q;
            prev_valid_q <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: if (out_if.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== verif/pnr_checker.sv =====
`timescale 1ns / 1ps

module pnr_checker
  import pnr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pnr_in_if           in_mon,
  pnr_out_if          out_mon,
  pnr_cfg_if          cfg_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [DataW-1:0] root;
    logic [StatW-1:0] status;
    logic [IterW-1:0] steps;
  } root_word_t;

  typedef logic signed [DataW-1:0] fx_t;
  typedef fx_t coef_arr_t [6];

  root_word_t      root_q[$];
  coef_arr_t       coef_q;
  logic [DegW-1:0] degree_q;
  logic [IterW-1:0] limit_q;
  fx_t             last_root_q;
  logic            last_root_vld_q;

  assign pending_o = root_q.size();

  function automatic fx_t clamp(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) return SatMax;
    if (v < -64'sh0000_0000_8000_0000) return SatMin;
    return v[DataW-1:0];
  endfunction

  // floor of the product / 2^16, via arithmetic shift
  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return clamp(p >>> 16);
  endfunction

  function automatic fx_t horner_eval(input coef_arr_t c, input int deg, input fx_t x);
    fx_t acc;
    acc = c[deg];
    for (int k = deg - 1; k >= 0; k--) begin
      acc = clamp(64'(fx_mul(acc, x)) + 64'(c[k]));
    end
    return acc;
  endfunction

  function automatic root_word_t solve_root(input fx_t guess);
    coef_arr_t  dcoef;
    int         deg;
    int         n;
    fx_t        x;
    fx_t        f;
    fx_t        df;
    fx_t        q;
    fx_t        xn;
    logic [StatW-1:0] st;
    root_word_t w;
    deg = (degree_q > DefMaxDegree) ? DefMaxDegree : int'(degree_q);
    for (int k = 0; k < 6; k++) dcoef[k] = '0;
    for (int k = 1; k <= deg; k++) dcoef[k-1] = clamp(64'(k) * 64'(coef_q[k]));
    x = guess;
    n = 0;
    st = StIterLimit;
    while (n < int'(limit_q)) begin
      f = horner_eval(coef_q, deg, x);
      df = (deg == 0) ? '0 : horner_eval(dcoef, deg - 1, x);
      if (df == 0) begin
        st = StZeroDeriv;
        break;
      end
      q = clamp((64'(f) * 64'sd65536) / 64'(df));
      xn = clamp(64'(x) - 64'(q));
      n++;
      if (xn == x) begin
        st = StConverged;
        break;
      end
      x = xn;
    end
    if (st != StZeroDeriv) begin
      if (last_root_vld_q && last_root_q == x) begin
        st = StDuplicate;
      end else begin
        last_root_q = x;
        last_root_vld_q = 1'b1;
      end
    end
    w.root = x;
    w.status = st;
    w.steps = n[IterW-1:0];
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    root_word_t want;
    if (!rst_ni) begin
      root_q.delete();
      for (int k = 0; k < 6; k++) coef_q[k] = '0;
      degree_q = 3'd1;
      limit_q = 8'd32;
      last_root_q = '0;
      last_root_vld_q = 1'b0;
      fail_cnt_o = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          RegDegree:    degree_q = cfg_mon.data[DegW-1:0];
          RegIterLimit: limit_q = cfg_mon.data[IterW-1:0];
          default:      coef_q[cfg_mon.index] = cfg_mon.data;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        root_q.push_back(solve_root(in_mon.start_guess));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (root_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("unexpected root word %h status %0d steps %0d", out_mon.root_value,
                     out_mon.result_status, out_mon.iterations_used);
        end else begin
          want = root_q.pop_front();
          if (want.root !== out_mon.root_value || want.status !== out_mon.result_status ||
              want.steps !== out_mon.iterations_used) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("root mismatch: exp %h/%0d/%0d got %h/%0d/%0d", want.root,
                       want.status, want.steps, out_mon.root_value,
                       out_mon.result_status, out_mon.iterations_used);
          end
        end
      end
    end
  end

endmodule

// ===== verif/polynomial_newton_root_top_test.sv =====
`timescale 1ns / 1ps

module polynomial_newton_root_top_test;
  import pnr_pkg::*;

  localparam logic [DataW-1:0] One = 32'h0001_0000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  bit          steady;
  bit          hold_req;
  logic [DataW-1:0] last_guess;

  pnr_in_if  in_if ();
  pnr_out_if out_if ();
  pnr_cfg_if cfg_if ();

  polynomial_newton_root_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  pnr_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (4000) @(negedge clk_i);
      end
      out_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  task automatic send_guess(input logic [DataW-1:0] g);
    if (!steady && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.start_guess <= g;
    last_guess = g;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] d);
    if (!steady && $urandom_range(99) < 14) begin
      cfg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drain every expected word, then let the block settle before a write
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic load_poly(input logic [DataW-1:0] c0, c1, c2, c3, c4, c5,
                           input logic [DataW-1:0] deg, lim);
    wait_idle();
    write_reg(3'd0, c0);
    write_reg(3'd1, c1);
    write_reg(3'd2, c2);
    write_reg(3'd3, c3);
    write_reg(3'd4, c4);
    write_reg(3'd5, c5);
    write_reg(RegDegree, deg);
    write_reg(RegIterLimit, lim);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] rand_coef();
    if ($urandom_range(9) < 8) return $signed($urandom) >>> 12;
    return $urandom;
  endfunction

  function automatic logic [DataW-1:0] rand_guess(input logic [DataW-1:0] prev);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return prev;
    if (r < 30) return $urandom;
    return $signed($urandom) >>> 12;
  endfunction

  initial begin
    logic [DataW-1:0] deg;
    logic [DataW-1:0] lim;
    int unsigned      r;
    rst_ni = 1'b0;
    steady = 1'b0;
    hold_req = 1'b0;
    last_guess = '0;
    in_if.valid = 1'b0;
    in_if.start_guess = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset config: p(x) = 0 everywhere, so f' is zero
    send_guess(32'h0003_0000);

    // x - 2: converge, then the same root again is a repeat
    load_poly(-32'sh0002_0000, One, 0, 0, 0, 0, 1, 32);
    send_guess(0);
    send_guess(32'h0005_0000);
    send_guess(32'h7fff_ffff);
    send_guess(32'h8000_0000);

    // x^2 - 4: zero derivative at the origin, roots at +-2
    load_poly(-32'sh0004_0000, 0, One, 0, 0, 0, 2, 32);
    send_guess(0);
    send_guess(32'h0001_0000);
    send_guess(32'hffff_0000);

    // x^2 + 1 has no real root: run out the largest limit
    load_poly(One, 0, One, 0, 0, 0, 2, 255);
    send_guess(32'h0000_8000);

    // limit zero: guess comes straight back, twice gives a repeat
    load_poly(One, One, 0, 0, 0, 0, 1, 0);
    send_guess(32'h1234_5678);
    send_guess(32'h1234_5678);

    // degree zero and degrees past the maximum
    load_poly(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 0, 8);
    send_guess(32'h0002_0000);
    load_poly(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 7, 8);
    send_guess(32'h0002_0000);
    send_guess(32'h8000_0000);
    load_poly(-32'sh0001_0000, 0, 0, 0, 0, One, 6, 40);
    send_guess(32'h0000_c000);
    send_guess(32'h7fff_ffff);

    // random phases; one long run without idling, one with a long output hold-off
    for (int ph = 0; ph < 13; ph++) begin
      r = $urandom_range(99);
      deg = (r < 8) ? $urandom_range(6, 7) : (r < 12) ? 0 : $urandom_range(1, 5);
      r = $urandom_range(99);
      lim = (r < 5) ? 0 : (r < 10) ? 255 : $urandom_range(1, 40);
      load_poly(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                rand_coef(), deg, lim);
      steady = (ph == 4);
      if (ph == 7) hold_req = 1'b1;
      for (int k = 0; k < ((lim == 255) ? 2 : 22); k++) send_guess(rand_guess(last_guess));
      steady = 1'b0;
    end

    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== polynomial_newton_root_top.f =====
design/pnr_pkg.sv
design/pnr_if.sv
design/polynomial_newton_root_top.sv
verif/pnr_checker.sv
verif/polynomial_newton_root_top_test.sv
